// ===== src/assert_macros.svh =====
// Assertion macros for the fit-to-viewport RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising clock edge outside reset.
`define SFV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define SFV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SFV_ASSERT(lbl, prop, msg)
`define SFV_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/sfv_pkg.sv =====
// Types, constants and codes shared by the fit-to-viewport block.
package sfv_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 64;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned WIN_W = 13;
  localparam int unsigned MARGIN_W = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DIV_STEPS = 45;

  localparam logic [WIN_W-1:0] WIN_WIDTH_RST = 13'd800;
  localparam logic [WIN_W-1:0] WIN_HEIGHT_RST = 13'd600;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 12'd0;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_WIDTH  = 2'd0,
    CFG_WINDOW_HEIGHT = 2'd1,
    CFG_BORDER_MARGIN = 2'd2
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_LOAD,
    S_DIVX_LD,
    S_DIVX_RUN,
    S_DIVY_LD,
    S_DIVY_RUN,
    S_READ,
    S_DIFF,
    S_MUL0,
    S_MUL1,
    S_RND,
    S_SAT,
    S_OUT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic load;
    logic div_ld_x;
    logic div_ld_y;
    logic div_step;
    logic save_x;
    logic save_y;
    logic rd;
    logic diff;
    logic mul0;
    logic mul1;
    logic rnd;
    logic sat;
    logic next_idx;
    logic clear;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic coord_last;
    logic idx_last;
  } dp_status_t;

endpackage

// ===== src/sfv_in_if.sv =====
// Segment input channel.
interface sfv_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic final_segment;

  modport source (output valid, start_x, start_y, end_x, end_y, final_segment, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, final_segment, output ready);
endinterface

// ===== src/sfv_out_if.sv =====
// Projected segment output channel.
interface sfv_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] screen_start_x;
  logic signed [31:0] screen_start_y;
  logic signed [31:0] screen_end_x;
  logic signed [31:0] screen_end_y;
  logic final_result;

  modport source (output valid, screen_start_x, screen_start_y, screen_end_x, screen_end_y,
                  final_result, input ready);
  modport sink (input valid, screen_start_x, screen_start_y, screen_end_x, screen_end_y,
                final_result, output ready);
endinterface

// ===== src/segment_fit_to_viewport.sv =====
// Top level: fits a set of segments into the viewport, keeping aspect ratio.
//
//   Channel   Direction  Transfer carries
//   seg_in_i  in         start_x, start_y, end_x, end_y, final_segment
//   seg_out_o out        screen_start_x/y, screen_end_x/y, final_result
//   cfg       in         write enable, register index, data
//
// Segments load one per cycle; the box update is a set of compares.
// After the final segment the shared divider finds the X scale, then the Y scale.
// Each result then takes a store read and four coordinates, each through difference,
// the two-part multiplier, rounding and saturation, then waits in its output register.
// Reset clears the box, counters and state; store contents are undefined.
// Input stays closed from the final segment until the last result transfers.
module segment_fit_to_viewport #(
  parameter int unsigned MAX_SEGMENTS = sfv_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sfv_in_if.sink                         seg_in_i,
  sfv_out_if.source                      seg_out_o
);

  sfv_pkg::ctrl_cmd_t  cmd;
  sfv_pkg::dp_status_t status;

  assign seg_in_i.ready  = cmd.in_ready;
  assign seg_out_o.valid = cmd.out_valid;

  sfv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seg_in_i.valid),
    .in_final_i  (seg_in_i.final_segment),
    .out_ready_i (seg_out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sfv_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .start_x_i        (seg_in_i.start_x),
    .start_y_i        (seg_in_i.start_y),
    .end_x_i          (seg_in_i.end_x),
    .end_y_i          (seg_in_i.end_y),
    .status_o         (status),
    .screen_start_x_o (seg_out_o.screen_start_x),
    .screen_start_y_o (seg_out_o.screen_start_y),
    .screen_end_x_o   (seg_out_o.screen_end_x),
    .screen_end_y_o   (seg_out_o.screen_end_y),
    .final_result_o   (seg_out_o.final_result)
  );

endmodule

// ===== src/sfv_ctrl.sv =====
// Controller state machine for the fit-to-viewport block.
`include "assert_macros.svh"

module sfv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_final_i,
  input  logic                out_ready_i,
  input  sfv_pkg::dp_status_t status_i,
  output sfv_pkg::ctrl_cmd_t  cmd_o
);

  sfv_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfv_pkg::S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      sfv_pkg::S_LOAD: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && in_final_i) state_d = sfv_pkg::S_DIVX_LD;
      end
      sfv_pkg::S_DIVX_LD: begin
        cmd_o.div_ld_x = 1'b1;
        state_d = sfv_pkg::S_DIVX_RUN;
      end
      sfv_pkg::S_DIVX_RUN: begin
        if (status_i.div_done) begin
          cmd_o.save_x = 1'b1;
          state_d = sfv_pkg::S_DIVY_LD;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      sfv_pkg::S_DIVY_LD: begin
        cmd_o.div_ld_y = 1'b1;
        state_d = sfv_pkg::S_DIVY_RUN;
      end
      sfv_pkg::S_DIVY_RUN: begin
        if (status_i.div_done) begin
          cmd_o.save_y = 1'b1;
          state_d = sfv_pkg::S_READ;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      sfv_pkg::S_READ: begin
        cmd_o.rd = 1'b1;
        state_d = sfv_pkg::S_DIFF;
      end
      sfv_pkg::S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d = sfv_pkg::S_MUL0;
      end
      sfv_pkg::S_MUL0: begin
        cmd_o.mul0 = 1'b1;
        state_d = sfv_pkg::S_MUL1;
      end
      sfv_pkg::S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = sfv_pkg::S_RND;
      end
      sfv_pkg::S_RND: begin
        cmd_o.rnd = 1'b1;
        state_d = sfv_pkg::S_SAT;
      end
      sfv_pkg::S_SAT: begin
        cmd_o.sat = 1'b1;
        state_d = status_i.coord_last ? sfv_pkg::S_OUT : sfv_pkg::S_DIFF;
      end
      sfv_pkg::S_OUT: begin
        cmd_o.out_valid = 1'b1;
        if (out_ready_i) begin
          if (status_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d = sfv_pkg::S_LOAD;
          end else begin
            cmd_o.next_idx = 1'b1;
            state_d = sfv_pkg::S_READ;
          end
        end
      end
      default: begin
        state_d = sfv_pkg::S_LOAD;
      end
    endcase
  end

  `SFV_ASSERT(a_ready_excl, cmd_o.in_ready |-> !cmd_o.out_valid, "input and output both open")
  `SFV_ASSERT(a_div_to_y, (state_q == sfv_pkg::S_DIVX_RUN && status_i.div_done) |=> (state_q == sfv_pkg::S_DIVY_LD), "Y division not started")
  `SFV_ASSERT(a_burst_end, (cmd_o.out_valid && out_ready_i && status_i.idx_last) |=> cmd_o.in_ready, "no return to loading after last result")

endmodule

// ===== src/sfv_datapath.sv =====
// Datapath: segment store, bounding box, scale divider and projection.
module sfv_datapath #(
  parameter int unsigned MAX_SEGMENTS = sfv_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sfv_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sfv_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  sfv_pkg::ctrl_cmd_t                  cmd_i,
  input  logic signed [sfv_pkg::COORD_W-1:0]  start_x_i,
  input  logic signed [sfv_pkg::COORD_W-1:0]  start_y_i,
  input  logic signed [sfv_pkg::COORD_W-1:0]  end_x_i,
  input  logic signed [sfv_pkg::COORD_W-1:0]  end_y_i,
  output sfv_pkg::dp_status_t                 status_o,
  output logic signed [sfv_pkg::COORD_W-1:0]  screen_start_x_o,
  output logic signed [sfv_pkg::COORD_W-1:0]  screen_start_y_o,
  output logic signed [sfv_pkg::COORD_W-1:0]  screen_end_x_o,
  output logic signed [sfv_pkg::COORD_W-1:0]  screen_end_y_o,
  output logic                                final_result_o
);

  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  // Configuration registers.
  logic [sfv_pkg::WIN_W-1:0]    win_w_q, win_h_q;
  logic [sfv_pkg::MARGIN_W-1:0] margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q  <= sfv_pkg::WIN_WIDTH_RST;
      win_h_q  <= sfv_pkg::WIN_HEIGHT_RST;
      margin_q <= sfv_pkg::MARGIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfv_pkg::CFG_WINDOW_WIDTH:  win_w_q <= cfg_data_i;
        sfv_pkg::CFG_WINDOW_HEIGHT: win_h_q <= cfg_data_i;
        sfv_pkg::CFG_BORDER_MARGIN: margin_q <= cfg_data_i[sfv_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Segment store, written while loading and read once per result.
  logic [4*sfv_pkg::COORD_W-1:0] mem [MAX_SEGMENTS];
  logic [4*sfv_pkg::COORD_W-1:0] rd_q;
  logic [CW-1:0] cnt_q, idx_q;
  logic          store_en;

  assign store_en = cmd_i.load && (cnt_q < CW'(MAX_SEGMENTS));

  always_ff @(posedge clk_i) begin
    if (store_en) mem[cnt_q[AW-1:0]] <= {end_y_i, end_x_i, start_y_i, start_x_i};
    if (cmd_i.rd) rd_q <= mem[idx_q[AW-1:0]];
  end

  // Bounding box and segment count.
  logic signed [sfv_pkg::COORD_W-1:0] lx_q, hx_q, ly_q, hy_q;

  function automatic logic signed [31:0] min3(input logic signed [31:0] a, b, c);
    logic signed [31:0] m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  function automatic logic signed [31:0] max3(input logic signed [31:0] a, b, c);
    logic signed [31:0] m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q  <= sfv_pkg::COORD_MAX;
      hx_q  <= sfv_pkg::COORD_MIN;
      ly_q  <= sfv_pkg::COORD_MAX;
      hy_q  <= sfv_pkg::COORD_MIN;
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      lx_q  <= sfv_pkg::COORD_MAX;
      hx_q  <= sfv_pkg::COORD_MIN;
      ly_q  <= sfv_pkg::COORD_MAX;
      hy_q  <= sfv_pkg::COORD_MIN;
      cnt_q <= '0;
    end else if (store_en) begin
      lx_q  <= min3(lx_q, start_x_i, end_x_i);
      hx_q  <= max3(hx_q, start_x_i, end_x_i);
      ly_q  <= min3(ly_q, start_y_i, end_y_i);
      hy_q  <= max3(hy_q, start_y_i, end_y_i);
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // Box extents and available sizes.
  logic [32:0] w_ext, h_ext;
  logic [31:0] box_w, box_h;
  logic [sfv_pkg::WIN_W-1:0] twice_margin, avail_x, avail_y;

  assign w_ext = {hx_q[31], hx_q} - {lx_q[31], lx_q};
  assign h_ext = {hy_q[31], hy_q} - {ly_q[31], ly_q};
  assign box_w = w_ext[31:0];
  assign box_h = h_ext[31:0];
  assign twice_margin = {margin_q, 1'b0};
  assign avail_x = (win_w_q > twice_margin) ? win_w_q - twice_margin : '0;
  assign avail_y = (win_h_q > twice_margin) ? win_h_q - twice_margin : '0;

  // Restoring divider, one quotient bit per cycle.
  logic [31:0] dvs_q, rem_q;
  logic [sfv_pkg::DIV_STEPS-1:0] dq_q;
  logic [5:0]  dcnt_q;
  logic [32:0] trial, trial_sub;
  logic        trial_ge;
  logic [31:0] q_sat, scx_q, scy, scale_q;

  assign trial     = {rem_q, dq_q[sfv_pkg::DIV_STEPS-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign trial_ge  = (trial >= {1'b0, dvs_q});
  assign q_sat     = (|dq_q[sfv_pkg::DIV_STEPS-1:32]) ? 32'hFFFF_FFFF : dq_q[31:0];
  assign scy       = (box_h == '0) ? scx_q : q_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q  <= '0;
      scale_q <= '0;
    end else begin
      if (cmd_i.div_ld_x || cmd_i.div_ld_y) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 6'd1;
      end
      if (cmd_i.save_y) scale_q <= (scx_q < scy) ? scx_q : scy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_ld_x) begin
      dvs_q <= box_w;
      rem_q <= '0;
      dq_q  <= {avail_x, 32'b0};
    end else if (cmd_i.div_ld_y) begin
      dvs_q <= box_h;
      rem_q <= '0;
      dq_q  <= {avail_y, 32'b0};
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_sub[31:0] : trial[31:0];
      dq_q  <= {dq_q[sfv_pkg::DIV_STEPS-2:0], trial_ge};
    end
    if (cmd_i.save_x) scx_q <= (box_w == '0) ? sfv_pkg::SCALE_ONE : q_sat;
  end

  // Emission counters.
  logic [1:0] coord_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      coord_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        idx_q <= '0;
      end else if (cmd_i.next_idx) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.clear) begin
        coord_q <= '0;
      end else if (cmd_i.sat) begin
        coord_q <= coord_q + 2'd1;
      end
    end
  end

  // Offset from the box centre in half-LSB units.
  logic                is_y;
  logic signed [31:0]  v, lo, hi;
  logic signed [34:0]  d;
  logic [33:0]         mag_q;
  logic                neg_q;
  logic [65:0]         p_q;
  logic [48:0]         r_q;
  logic [65:0]         p_rnd;

  assign is_y = coord_q[0];
  assign v    = rd_q[coord_q*sfv_pkg::COORD_W +: sfv_pkg::COORD_W];
  assign lo   = is_y ? ly_q : lx_q;
  assign hi   = is_y ? hy_q : hx_q;
  assign d    = {{2{v[31]}}, v, 1'b0} - ({{3{lo[31]}}, lo} + {{3{hi[31]}}, hi});
  assign p_rnd = p_q + 66'h1_0000;

  // Multiply in two partial products, then round and place.
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      neg_q <= d[34];
      mag_q <= d[34] ? 34'(-d) : d[33:0];
    end
    if (cmd_i.mul0) p_q <= 66'(49'(mag_q[16:0]) * 49'(scale_q));
    if (cmd_i.mul1) p_q <= p_q + {49'(mag_q[33:17]) * 49'(scale_q), 17'b0};
    if (cmd_i.rnd)  r_q <= p_rnd[65:17];
  end

  logic [27:0]        centre;
  logic signed [50:0] placed;
  logic [31:0]        placed_sat;
  logic [4*sfv_pkg::COORD_W-1:0] res_q;

  assign centre = is_y ? {win_h_q, 15'b0} : {win_w_q, 15'b0};
  assign placed = (neg_q ^ is_y) ? $signed({23'b0, centre}) - $signed({2'b0, r_q})
                                 : $signed({23'b0, centre}) + $signed({2'b0, r_q});
  assign placed_sat = (placed[50:31] == {20{placed[50]}}) ? placed[31:0]
                    : (placed[50] ? sfv_pkg::COORD_MIN : sfv_pkg::COORD_MAX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sat) res_q[coord_q*sfv_pkg::COORD_W +: sfv_pkg::COORD_W] <= placed_sat;
  end

  // Results and status.
  assign screen_start_x_o = res_q[31:0];
  assign screen_start_y_o = res_q[63:32];
  assign screen_end_x_o   = res_q[95:64];
  assign screen_end_y_o   = res_q[127:96];
  assign final_result_o   = status_o.idx_last;

  assign status_o.div_done   = (dcnt_q == 6'(sfv_pkg::DIV_STEPS));
  assign status_o.coord_last = (coord_q == 2'd3);
  assign status_o.idx_last   = ((idx_q + CW'(1)) == cnt_q);

endmodule
